@@ rtl/bcc_pkg.sv @@
// Shared types for the bit-serial binomial coefficient core.
package bcc_pkg;

    // Width of the visible result and of each output half
    localparam int VALUE_BITS = 128;
    localparam int HALF_BITS  = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // Per-cycle control of a serial arithmetic cell
    typedef struct packed {
        logic en;     // a bit passes through this cycle
        logic first;  // first bit of a pass: start from a clean carry/remainder
    } t_cell_ctl;

endpackage

@@ rtl/bcc_mul_cell.sv @@
// Bit-serial multiply-by-constant cell, LSB first, carry kept in a register.
module bcc_mul_cell
    import bcc_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  t_cell_ctl    i_ctl,
    input  logic         i_bit,
    input  logic [W-1:0] i_mult,
    output logic         o_bit
);

    logic [W-1:0] r_carry;
    logic [W-1:0] n_carry;
    logic [W-1:0] w_carry_in;
    logic [W:0]   w_sum;

    // carry stays below the multiplier, so W bits hold it
    assign w_carry_in = i_ctl.first ? '0 : r_carry;
    assign w_sum      = {1'b0, w_carry_in} + (i_bit ? {1'b0, i_mult} : '0);
    assign o_bit      = w_sum[0];
    assign n_carry    = w_sum[W:1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_carry <= n_carry;
        end
    end

endmodule

@@ rtl/bcc_div_cell.sv @@
// Bit-serial restoring divider cell, MSB first, remainder kept in a register.
module bcc_div_cell
    import bcc_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  t_cell_ctl    i_ctl,
    input  logic         i_bit,
    input  logic [W-1:0] i_divisor,
    output logic         o_bit
);

    logic [W-1:0] r_rem;
    logic [W-1:0] n_rem;
    logic [W-1:0] w_rem_in;
    logic [W:0]   w_shift;
    logic [W:0]   w_diff;

    assign w_rem_in = i_ctl.first ? '0 : r_rem;
    assign w_shift  = {w_rem_in, i_bit};
    assign w_diff   = w_shift - {1'b0, i_divisor};
    assign o_bit    = (w_shift >= {1'b0, i_divisor});
    // remainder is always below the divisor
    assign n_rem    = o_bit ? w_diff[W-1:0] : w_shift[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem <= n_rem;
        end
    end

endmodule

@@ rtl/binomial_coefficient_core.sv @@
// Top level: binomial coefficient C(n,k) by the multiplicative scheme, bit-serial.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | start / busy       | i_set_size, i_choose_count
//  result    | o_done (strobe)    | o_value_low, o_value_high, o_truncated
//
// A request transfers at an edge with start high and busy low; busy stays high
// until the result strobe has passed. k > n, k = 0 and k = 1 (after k is
// reflected to min(k, n-k)) go straight from idle to the result. Otherwise the
// accumulator runs one multiply pass and one divide pass per step i = 2..k,
// each pass shifting all ACC_BITS accumulator bits through a one-bit cell.
// Reset (synchronous, active low) returns the sequencer to idle; the datapath
// needs no reset. The result is shown for one cycle and the receiver cannot
// stall it.
module binomial_coefficient_core
    import bcc_pkg::*;
#(
    parameter int OPERAND_BITS = 8,
    parameter int ACC_BITS     = 256,
    parameter int RESULT_BITS  = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OPERAND_BITS-1:0] i_set_size,
    input  logic [OPERAND_BITS-1:0] i_choose_count,
    output logic                    o_done,
    output logic [HALF_BITS-1:0]    o_value_low,
    output logic [HALF_BITS-1:0]    o_value_high,
    output logic                    o_truncated
);

    localparam int W     = OPERAND_BITS;
    localparam int CNT_W = $clog2(ACC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_BITS - 1);

    t_state r_state, n_state;

    logic [ACC_BITS-1:0] r_acc, n_acc;  // shift register accumulator
    logic [W-1:0]        r_n, r_k, r_i; // n, reflected k, step index
    logic [W-1:0]        n_n, n_k, n_i;
    logic [CNT_W-1:0]    r_cnt, n_cnt;  // bit position within a pass

    logic       w_accept;
    logic       w_last_bit;
    logic       w_last_step;
    logic [W-1:0] w_kref;
    logic [W-1:0] w_mult;
    logic       w_mul_bit, w_div_bit;
    t_cell_ctl  w_mul_ctl, w_div_ctl;

    assign w_accept    = start && !busy;
    assign w_last_bit  = (r_cnt == CNT_LAST);
    assign w_last_step = (r_i == r_k);
    // k reflected to n-k when that is smaller
    assign w_kref      = ({i_choose_count, 1'b0} > {1'b0, i_set_size}) ?
                         (i_set_size - i_choose_count) : i_choose_count;
    // n-i+1 stays positive since n >= 2k >= 2i
    assign w_mult      = r_n - r_i + W'(1);

    assign w_mul_ctl.en    = (r_state == ST_MUL);
    assign w_mul_ctl.first = (r_cnt == '0);
    assign w_div_ctl.en    = (r_state == ST_DIV);
    assign w_div_ctl.first = (r_cnt == '0);

    bcc_mul_cell #(.W(W)) u_mul (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_bit  (r_acc[0]),
        .i_mult (w_mult),
        .o_bit  (w_mul_bit)
    );

    bcc_div_cell #(.W(W)) u_div (
        .i_clk     (i_clk),
        .i_ctl     (w_div_ctl),
        .i_bit     (r_acc[ACC_BITS-1]),
        .i_divisor (r_i),
        .o_bit     (w_div_bit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_choose_count > i_set_size || w_kref < W'(2)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (w_last_bit) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_last_bit) n_state = w_last_step ? ST_DONE : ST_MUL;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_acc = r_acc;
        n_n   = r_n;
        n_k   = r_k;
        n_i   = r_i;
        n_cnt = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_n = i_set_size;
                    n_k = w_kref;
                    n_i = W'(2);
                    priority if (i_choose_count > i_set_size) begin
                        n_acc = '0;
                    end else if (w_kref == '0) begin
                        n_acc = ACC_BITS'(1);
                    end else begin
                        n_acc = ACC_BITS'(i_set_size);
                    end
                end
            end
            ST_MUL: begin
                // LSB first; the final carry falls off (wrap mod 2^ACC_BITS)
                n_acc = {w_mul_bit, r_acc[ACC_BITS-1:1]};
                n_cnt = w_last_bit ? '0 : r_cnt + CNT_W'(1);
            end
            ST_DIV: begin
                // MSB first; quotient bits enter at the bottom
                n_acc = {r_acc[ACC_BITS-2:0], w_div_bit};
                n_cnt = w_last_bit ? '0 : r_cnt + CNT_W'(1);
                if (w_last_bit && !w_last_step) n_i = r_i + W'(1);
            end
            ST_DONE: n_cnt = '0;
            default: n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_n   <= n_n;
        r_k   <= n_k;
        r_i   <= n_i;
    end

    // outputs
    always_comb begin
        busy   = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
    end

    logic [VALUE_BITS-1:0] w_value;

    for (genvar b = 0; b < VALUE_BITS; b++) begin : g_value
        if (b < RESULT_BITS && b < ACC_BITS) begin : g_bit
            assign w_value[b] = r_acc[b];
        end else begin : g_zero
            assign w_value[b] = 1'b0;
        end
    end

    if (RESULT_BITS < ACC_BITS) begin : g_trunc
        assign o_truncated = |r_acc[ACC_BITS-1:RESULT_BITS];
    end else begin : g_no_trunc
        assign o_truncated = 1'b0;
    end

    assign o_value_low  = w_value[HALF_BITS-1:0];
    assign o_value_high = w_value[VALUE_BITS-1:HALF_BITS];

    // checks
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_busy_ends_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a result");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted request did not raise busy");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_DIV) |-> (r_i >= W'(2) && r_i <= r_k))
        else $error("step index outside 2..k");

endmodule

@@ tb/binomial_coefficient_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the binomial coefficient core: predicts each request, checks each strobe.
module binomial_coefficient_checker
    import bcc_pkg::*;
#(
    parameter int OPERAND_BITS = 8,
    parameter int ACC_BITS     = 256,
    parameter int RESULT_BITS  = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [OPERAND_BITS-1:0] i_set_size,
    input  logic [OPERAND_BITS-1:0] i_choose_count,
    input  logic                    o_done,
    input  logic [HALF_BITS-1:0]    o_value_low,
    input  logic [HALF_BITS-1:0]    o_value_high,
    input  logic                    o_truncated,
    output int                      o_mismatches,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_dropped
);

    typedef struct {
        logic [HALF_BITS-1:0] low;
        logic [HALF_BITS-1:0] high;
        logic                 trunc;
    } t_coef;

    t_coef coef_expected_q[$];

    // C(n,k) with a fixed-width accumulator: multiply wraps, then floor divide
    function automatic t_coef binomial_trunc(input logic [OPERAND_BITS-1:0] n_in,
                                             input logic [OPERAND_BITS-1:0] k_in);
        logic [ACC_BITS-1:0]            acc;
        logic [ACC_BITS-1:0]            factor;
        logic [ACC_BITS-1:0]            above;
        logic [ACC_BITS+VALUE_BITS-1:0] visible;
        int                             n;
        int                             k;
        t_coef                          res;
        n   = n_in;
        k   = k_in;
        acc = '0;
        if (k <= n) begin
            if (2 * k > n)
                k = n - k;
            if (k == 0) begin
                acc = ACC_BITS'(1);
            end else begin
                acc = ACC_BITS'(n);
                for (int i = 2; i <= k; i++) begin
                    factor = ACC_BITS'(n - i + 1);
                    acc    = acc * factor;
                    factor = ACC_BITS'(i);
                    acc    = acc / factor;
                end
            end
        end
        above     = acc >> RESULT_BITS;
        visible   = '0;
        visible[ACC_BITS-1:0] = acc ^ (above << RESULT_BITS);
        res.low   = visible[HALF_BITS-1:0];
        res.high  = visible[VALUE_BITS-1:HALF_BITS];
        res.trunc = |above;
        return res;
    endfunction

    // Result is compared before a same-edge request is queued
    always @(posedge i_clk) begin
        t_coef want;
        int    bad;
        bad = 0;
        if (i_rst_n) begin
            if (o_done) begin
                if (coef_expected_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    bad++;
                end else begin
                    want = coef_expected_q.pop_front();
                    if (o_value_low !== want.low) begin
                        $error("value_low: expected %h, got %h", want.low, o_value_low);
                        bad++;
                    end
                    if (o_value_high !== want.high) begin
                        $error("value_high: expected %h, got %h", want.high, o_value_high);
                        bad++;
                    end
                    if (o_truncated !== want.trunc) begin
                        $error("truncated: expected %b, got %b", want.trunc, o_truncated);
                        bad++;
                    end
                    o_checked <= o_checked + 1;
                    if (want.trunc)
                        o_dropped <= o_dropped + 1;
                end
            end
            if (start && !busy)
                coef_expected_q.push_back(binomial_trunc(i_set_size, i_choose_count));
        end
        o_mismatches <= o_mismatches + bad;
        o_pending    <= coef_expected_q.size();
    end

endmodule

@@ tb/binomial_coefficient_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the binomial coefficient core: stimulus, watchdog and verdict.
module binomial_coefficient_core_tb
    import bcc_pkg::*;
();

    localparam int OPERAND_BITS = 8;
    localparam int ACC_BITS     = 256;
    localparam int RESULT_BITS  = 128;
    localparam int OP_MAX       = (1 << OPERAND_BITS) - 1;

    // Worst request (n = 254, k = 127) keeps busy high with no transfer at all,
    // so the limit must cover its whole run.
    localparam int STALL_LIMIT  = 200_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 125;
    // Reflected k above this counts as a long chain
    localparam int SHORT_CHAIN  = 8;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    start          = 1'b0;
    logic [OPERAND_BITS-1:0] i_set_size     = '0;
    logic [OPERAND_BITS-1:0] i_choose_count = '0;
    logic                    busy;
    logic                    o_done;
    logic [HALF_BITS-1:0]    o_value_low;
    logic [HALF_BITS-1:0]    o_value_high;
    logic                    o_truncated;

    int mismatches;
    int pending;
    int checked;
    int dropped;
    int requests_sent = 0;
    int directed_sent = 0;
    int idle_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    binomial_coefficient_core #(
        .OPERAND_BITS(OPERAND_BITS),
        .ACC_BITS    (ACC_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_set_size    (i_set_size),
        .i_choose_count(i_choose_count),
        .o_done        (o_done),
        .o_value_low   (o_value_low),
        .o_value_high  (o_value_high),
        .o_truncated   (o_truncated)
    );

    binomial_coefficient_checker #(
        .OPERAND_BITS(OPERAND_BITS),
        .ACC_BITS    (ACC_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_set_size    (i_set_size),
        .i_choose_count(i_choose_count),
        .o_done        (o_done),
        .o_value_low   (o_value_low),
        .o_value_high  (o_value_high),
        .o_truncated   (o_truncated),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_dropped     (dropped)
    );

    // Watchdog: any request or result transfer clears the stall count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One request transfer. An optional gap drops start first; with no gap,
    // start stays high and only the operands change, so start never gets
    // two updates in one step. Returns on the edge the request transfers.
    task automatic send_request(input int n, input int k);
        int gap;
        // Every 32 requests: 8 back to back, then random gaps
        gap = (requests_sent % 32 < 8) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_set_size     <= OPERAND_BITS'(n);
        i_choose_count <= OPERAND_BITS'(k);
        do @(posedge i_clk); while (busy);
        requests_sent++;
    endtask

    initial begin
        int n;
        int k;
        int r;
        int kind;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty and full sets, k > n, reflection, k = 0 and 1
        send_request(0, 0);
        send_request(0, 1);
        send_request(0, OP_MAX);
        send_request(7, 8);
        send_request(OP_MAX - 1, OP_MAX);
        send_request(OP_MAX, 0);
        send_request(OP_MAX, OP_MAX);
        send_request(OP_MAX, 1);
        send_request(OP_MAX, OP_MAX - 1);
        send_request(1, 1);
        send_request(2, 1);
        send_request(10, 3);
        send_request(10, 5);
        send_request(10, 7);
        // Results growing into value_high, then just past 128 bits
        send_request(64, 32);
        send_request(70, 35);
        send_request(100, 50);
        send_request(130, 65);
        send_request(132, 66);
        // Deepest chains: the product wraps the accumulator before division
        send_request(OP_MAX - 1, (OP_MAX - 1) / 2);
        send_request(OP_MAX, OP_MAX / 2);
        directed_sent = requests_sent;

        // Random: mostly short chains (either side of reflection), some k > n,
        // a few full-range k to keep runtime bounded
        for (int j = 0; j < RANDOM_ITEMS; j++) begin
            kind = $urandom_range(0, 99);
            n    = $urandom_range(0, OP_MAX);
            if (kind < 10) begin
                n = $urandom_range(0, OP_MAX - 1);
                k = $urandom_range(n + 1, OP_MAX);
            end else if (kind < 15) begin
                k = $urandom_range(0, n);
            end else begin
                r = $urandom_range(0, (n < SHORT_CHAIN) ? n : SHORT_CHAIN);
                k = $urandom_range(0, 1) ? r : n - r;
            end
            send_request(n, k);
        end
        start <= 1'b0;

        // Pending count is registered in the checker, so it lags the transfer
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed), checked %0d results, %0d truncated.",
                 requests_sent, directed_sent, checked, dropped);
        $display("Random mix: short chains near both ends of k, k above n, some full-range k.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ binomial_coefficient_core.f @@
rtl/bcc_pkg.sv
rtl/bcc_mul_cell.sv
rtl/bcc_div_cell.sv
rtl/binomial_coefficient_core.sv
tb/binomial_coefficient_checker.sv
tb/binomial_coefficient_core_tb.sv
